// File: hdl/semaphore_wait_queue_manager_unit_macros.svh
// assertion macros for the semaphore wait queue manager
// used by the top level; expects clk and rst_n in scope
`ifndef SEMAPHORE_WAIT_QUEUE_MANAGER_UNIT_MACROS_SVH
`define SEMAPHORE_WAIT_QUEUE_MANAGER_UNIT_MACROS_SVH

// plain property checked while out of reset
`define SWQM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent this cycle, consequent in the next cycle
`define SWQM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// antecedent and consequent in the same cycle
`define SWQM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/swqm_pkg.sv
// shared types and codes for the semaphore wait queue manager
// no dependencies
package swqm_pkg;

  localparam int PW    = 5;
  localparam int NPROC = 32;

  typedef enum logic [1:0] {
    OP_BLOCK   = 2'd0,
    OP_WAKE    = 2'd1,
    OP_UNBLOCK = 2'd2,
    OP_PEEK    = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic key_we;
    logic head_we;
    logic tail_we;
    logic valid_set;
    logic valid_clr;
  } desc_wr_t;

  typedef struct packed {
    logic          link_we;
    logic          desc_we;
    logic          wait_set;
    logic          wait_clr;
    logic [PW-1:0] wait_idx;
  } proc_wr_t;

endpackage

// File: hdl/swqm_desc_store.sv
// descriptor memory: key, head and tail arrays plus valid flags
// depends on swqm_pkg
module swqm_desc_store import swqm_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int KW    = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_valid,
  output logic [KW-1:0] rd_key,
  output logic [PW-1:0] rd_head,
  output logic [PW-1:0] rd_tail,
  input  logic [AW-1:0] wr_addr,
  input  desc_wr_t      wr_ctl,
  input  logic [KW-1:0] wr_key,
  input  logic [PW-1:0] wr_head,
  input  logic [PW-1:0] wr_tail
);

  logic [KW-1:0] key_mem  [DEPTH];
  logic [PW-1:0] head_mem [DEPTH];
  logic [PW-1:0] tail_mem [DEPTH];
  logic [DEPTH-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (wr_ctl.key_we) key_mem[wr_addr] <= wr_key;
    if (wr_ctl.head_we) head_mem[wr_addr] <= wr_head;
    if (wr_ctl.tail_we) tail_mem[wr_addr] <= wr_tail;
    rd_key  <= key_mem[rd_addr];
    rd_head <= head_mem[rd_addr];
    rd_tail <= tail_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_ctl.valid_set) valid_r[wr_addr] <= 1'b1;
      else if (wr_ctl.valid_clr) valid_r[wr_addr] <= 1'b0;
      rd_valid <= valid_r[rd_addr];
    end
  end

endmodule

// File: hdl/swqm_proc_store.sv
// per-process memory: queue link and owning descriptor, plus waiting flags
// depends on swqm_pkg
module swqm_proc_store import swqm_pkg::*; #(
  parameter int DW = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [PW-1:0]    rd_addr,
  output logic [PW-1:0]    rd_link,
  output logic [DW-1:0]    rd_desc,
  input  logic [PW-1:0]    wr_addr,
  input  proc_wr_t         wr_ctl,
  input  logic [PW-1:0]    wr_link,
  input  logic [DW-1:0]    wr_desc,
  output logic [NPROC-1:0] waiting
);

  logic [PW-1:0]    link_mem [NPROC];
  logic [DW-1:0]    desc_mem [NPROC];
  logic [NPROC-1:0] waiting_r;

  always_ff @(posedge clk) begin
    if (wr_ctl.link_we) link_mem[wr_addr] <= wr_link;
    if (wr_ctl.desc_we) desc_mem[wr_addr] <= wr_desc;
    rd_link <= link_mem[rd_addr];
    rd_desc <= desc_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r <= '0;
    end else if (wr_ctl.wait_set) begin
      waiting_r[wr_ctl.wait_idx] <= 1'b1;
    end else if (wr_ctl.wait_clr) begin
      waiting_r[wr_ctl.wait_idx] <= 1'b0;
    end
  end

  assign waiting = waiting_r;

endmodule

// File: hdl/semaphore_wait_queue_manager_unit.sv
// block/wake/peek scan the descriptor memory one entry a cycle; unblock walks the queue
// links one hop a cycle; rejected items go straight to S_DONE
// throughput: one item at a time, set by the single read port of each memory; the next
// transfer in can be taken in the cycle after the result register loads
// reset: all descriptors free and no process waiting; no clearing pass needed
module semaphore_wait_queue_manager_unit import swqm_pkg::*; #(
  parameter int MAX_PROCS = 32,
  parameter int KEY_BITS  = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_op,
  input  logic [31:0]   in_sem_key,
  input  logic [4:0]    in_proc_id,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic [4:0]    out_result_proc
);
`include "semaphore_wait_queue_manager_unit_macros.svh"

  localparam int DW = $clog2(MAX_PROCS);
  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_B_NEW, S_B_APP, S_B_FIN, S_W_WR,
    S_U_RDP, S_U_RDD, S_U_CHK, S_DONE
  } state_t;

  state_t        state_r;
  op_t           op_r;
  logic [KW-1:0] key_r;
  logic [PW-1:0] p_r, head_r, tail_r, prev_r, plink_r, res_r;
  logic [1:0]    st_r;
  logic [DW-1:0] d_r, free_r, chk_idx_r;
  logic [DW:0]   cnt_r;
  logic          chk_v_r, free_found_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [PW-1:0] out_res_r;

  logic [DW-1:0]    drd_addr, dwr_addr;
  logic             drd_valid;
  logic [KW-1:0]    drd_key;
  logic [PW-1:0]    drd_head, drd_tail, dwr_head, dwr_tail;
  desc_wr_t         dwr;
  logic [PW-1:0]    prd_addr, prd_link, pwr_addr, pwr_link;
  logic [DW-1:0]    prd_desc;
  proc_wr_t         pwr;
  logic [NPROC-1:0] waiting;

  logic in_xfer, p_ok, cnt_live, scan_found, scan_last, free_now;

  assign in_xfer    = in_valid && in_ready;
  assign p_ok       = (32'(in_proc_id) < MAX_PROCS);
  assign cnt_live   = (32'(cnt_r) < MAX_PROCS);
  assign scan_found = chk_v_r && drd_valid && (drd_key == key_r);
  assign scan_last  = chk_v_r && (chk_idx_r == DW'(MAX_PROCS - 1));
  assign free_now   = chk_v_r && !drd_valid && !free_found_r;

  swqm_desc_store #(.DEPTH(MAX_PROCS), .AW(DW), .KW(KW)) u_desc (
    .clk, .rst_n,
    .rd_addr(drd_addr), .rd_valid(drd_valid), .rd_key(drd_key),
    .rd_head(drd_head), .rd_tail(drd_tail),
    .wr_addr(dwr_addr), .wr_ctl(dwr), .wr_key(key_r),
    .wr_head(dwr_head), .wr_tail(dwr_tail)
  );

  swqm_proc_store #(.DW(DW)) u_proc (
    .clk, .rst_n,
    .rd_addr(prd_addr), .rd_link(prd_link), .rd_desc(prd_desc),
    .wr_addr(pwr_addr), .wr_ctl(pwr), .wr_link(pwr_link), .wr_desc(d_r),
    .waiting
  );

  // read addresses and write strobes
  always_comb begin
    drd_addr = d_r;
    prd_addr = p_r;
    dwr      = '0;
    dwr_addr = d_r;
    dwr_head = p_r;
    dwr_tail = p_r;
    pwr      = '0;
    pwr_addr = p_r;
    pwr_link = p_r;
    pwr.wait_idx = p_r;
    case (state_r)
      S_IDLE: prd_addr = in_proc_id;
      S_SCAN: begin
        drd_addr = cnt_r[DW-1:0];
        prd_addr = drd_head;
        if (scan_found && op_r == OP_WAKE && drd_head == drd_tail) begin
          dwr.valid_clr = 1'b1;
          dwr_addr      = chk_idx_r;
          pwr.wait_clr  = 1'b1;
          pwr.wait_idx  = drd_head;
        end
      end
      S_B_NEW: begin
        dwr.key_we    = 1'b1;
        dwr.head_we   = 1'b1;
        dwr.tail_we   = 1'b1;
        dwr.valid_set = 1'b1;
      end
      S_B_APP: begin
        dwr.tail_we = 1'b1;
        pwr.link_we = 1'b1;
        pwr_addr    = tail_r;
      end
      S_B_FIN: begin
        pwr.link_we  = 1'b1;
        pwr.desc_we  = 1'b1;
        pwr.wait_set = 1'b1;
        pwr_link     = '0;
      end
      S_W_WR: begin
        dwr.head_we  = 1'b1;
        dwr_head     = prd_link;
        pwr.wait_clr = 1'b1;
        pwr.wait_idx = head_r;
      end
      S_U_RDP: drd_addr = prd_desc;
      S_U_RDD: begin
        prd_addr = drd_head;
        if (drd_valid && drd_head == p_r) begin
          pwr.wait_clr = 1'b1;
          if (drd_tail == p_r) begin
            dwr.valid_clr = 1'b1;
          end else begin
            dwr.head_we = 1'b1;
            dwr_head    = plink_r;
          end
        end
      end
      S_U_CHK: begin
        prd_addr = prd_link;
        if (prd_link == p_r) begin
          pwr.wait_clr = 1'b1;
          pwr.link_we  = 1'b1;
          pwr_addr     = prev_r;
          pwr_link     = plink_r;
          dwr.tail_we  = (tail_r == p_r);
          dwr_tail     = prev_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      chk_v_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            op_r         <= op_t'(in_op);
            key_r        <= in_sem_key[KW-1:0];
            p_r          <= in_proc_id;
            cnt_r        <= '0;
            chk_v_r      <= 1'b0;
            free_found_r <= 1'b0;
            st_r         <= ST_MISS;
            res_r        <= '0;
            case (op_t'(in_op))
              OP_BLOCK:   state_r <= (p_ok && !waiting[in_proc_id]) ? S_SCAN : S_DONE;
              OP_UNBLOCK: state_r <= (p_ok && waiting[in_proc_id]) ? S_U_RDP : S_DONE;
              default:    state_r <= S_SCAN;
            endcase
          end
        end
        S_SCAN: begin
          cnt_r     <= cnt_live ? cnt_r + 1'b1 : cnt_r;
          chk_v_r   <= cnt_live;
          chk_idx_r <= cnt_r[DW-1:0];
          if (free_now) begin
            free_r       <= chk_idx_r;
            free_found_r <= 1'b1;
          end
          if (scan_found) begin
            d_r    <= chk_idx_r;
            head_r <= drd_head;
            tail_r <= drd_tail;
            case (op_r)
              OP_BLOCK: state_r <= S_B_APP;
              OP_WAKE: begin
                st_r    <= ST_OK;
                res_r   <= drd_head;
                state_r <= (drd_head == drd_tail) ? S_DONE : S_W_WR;
              end
              default: begin
                st_r    <= ST_OK;
                res_r   <= drd_head;
                state_r <= S_DONE;
              end
            endcase
          end else if (scan_last) begin
            if (op_r == OP_BLOCK && (free_now || free_found_r)) begin
              d_r     <= free_now ? chk_idx_r : free_r;
              state_r <= S_B_NEW;
            end else begin
              st_r    <= (op_r == OP_BLOCK) ? ST_FULL : ST_MISS;
              state_r <= S_DONE;
            end
          end
        end
        S_B_NEW, S_B_APP: state_r <= S_B_FIN;
        S_B_FIN: begin
          st_r    <= ST_OK;
          state_r <= S_DONE;
        end
        S_W_WR: state_r <= S_DONE;
        S_U_RDP: begin
          plink_r <= prd_link;
          d_r     <= prd_desc;
          state_r <= S_U_RDD;
        end
        S_U_RDD: begin
          if (!drd_valid) begin
            state_r <= S_DONE;
          end else if (drd_head == p_r) begin
            st_r    <= ST_OK;
            res_r   <= p_r;
            state_r <= S_DONE;
          end else begin
            prev_r  <= drd_head;
            tail_r  <= drd_tail;
            state_r <= S_U_CHK;
          end
        end
        S_U_CHK: begin
          if (prd_link == p_r) begin
            st_r    <= ST_OK;
            res_r   <= p_r;
            state_r <= S_DONE;
          end else if (prev_r == tail_r) begin
            state_r <= S_DONE;
          end else begin
            prev_r <= prd_link;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= st_r;
            out_res_r    <= (st_r == ST_OK) ? res_r : '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_proc = out_res_r;

  `SWQM_ASSERT_NEXT(a_one_item, in_xfer, !in_ready, "second item taken while busy")
  `SWQM_ASSERT_IMP(a_res_zero, out_valid && out_status != ST_OK, out_result_proc == '0,
                   "nonzero process on failed result")
  `SWQM_ASSERT_IMP(a_status_code, out_valid,
                   out_status == ST_OK || out_status == ST_MISS || out_status == ST_FULL,
                   "undefined status code")
  `SWQM_ASSERT(a_valid_wr, $onehot0({dwr.valid_set, dwr.valid_clr}),
               "descriptor set and freed together")

endmodule

// File: bench/tb_top.sv
// testbench for semaphore_wait_queue_manager_unit: drives block, wake, unblock and peek
// transfers and compares each result with a behavioral queue predictor; depends on swqm_pkg
`timescale 1ns / 100ps

module tb_top;
  import swqm_pkg::*;

  localparam int NP        = 32;
  localparam int IDLE_MAX  = 20000;
  localparam int DRAIN_CYC = 80;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [31:0] in_sem_key;
  logic [4:0]  in_proc_id;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [4:0]  out_result_proc;

  semaphore_wait_queue_manager_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .in_sem_key(in_sem_key), .in_proc_id(in_proc_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_result_proc(out_result_proc)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // predictor state: one fifo of waiting processes per descriptor
  logic [31:0] sem_key_of[NP];
  bit          sem_busy[NP];
  logic [4:0]  sem_queue[NP][$];
  bit          proc_blocked[NP];
  int          proc_sem[NP];

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] proc_num;
  } sem_reply_t;

  sem_reply_t replies_due[$];
  int  fail_cnt;
  bit  hold_off;
  bit  long_stall;
  int  idle_cycles;
  logic [31:0] key_pool[8];

  function automatic int find_sem(logic [31:0] k);
    for (int d = 0; d < NP; d++)
      if (sem_busy[d] && sem_key_of[d] == k) return d;
    return -1;
  endfunction

  function automatic sem_reply_t predict_sem_op(op_t op, logic [31:0] k, logic [4:0] p);
    sem_reply_t r;
    int d;
    r = '{status: ST_MISS, proc_num: '0};
    case (op)
      OP_BLOCK: begin
        if (!proc_blocked[p]) begin
          d = find_sem(k);
          if (d < 0) begin
            for (int i = 0; i < NP; i++)
              if (!sem_busy[i]) begin d = i; break; end
            if (d < 0) r.status = ST_FULL;
            else begin
              sem_busy[d] = 1'b1;
              sem_key_of[d] = k;
              sem_queue[d].delete();
            end
          end
          if (d >= 0) begin
            sem_queue[d].push_back(p);
            proc_blocked[p] = 1'b1;
            proc_sem[p] = d;
            r.status = ST_OK;
          end
        end
      end
      OP_WAKE, OP_PEEK: begin
        d = find_sem(k);
        if (d >= 0) begin
          r = '{status: ST_OK, proc_num: sem_queue[d][0]};
          if (op == OP_WAKE) begin
            void'(sem_queue[d].pop_front());
            proc_blocked[r.proc_num] = 1'b0;
            if (sem_queue[d].size() == 0) sem_busy[d] = 1'b0;
          end
        end
      end
      default: begin
        if (proc_blocked[p]) begin
          d = proc_sem[p];
          foreach (sem_queue[d][i])
            if (sem_queue[d][i] == p) begin
              sem_queue[d].delete(i);
              break;
            end
          if (sem_queue[d].size() == 0) sem_busy[d] = 1'b0;
          proc_blocked[p] = 1'b0;
          r = '{status: ST_OK, proc_num: p};
        end
      end
    endcase
    return r;
  endfunction

  // valid drops for one cycle after each transfer; the block is busy then anyway
  task automatic send_op(op_t op, logic [31:0] k, logic [4:0] p);
    in_valid   <= 1'b1;
    in_op      <= op;
    in_sem_key <= k;
    in_proc_id <= p;
    do @(posedge clk); while (!in_ready);
    replies_due.push_back(predict_sem_op(op, k, p));
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_gap();
    int n;
    if ($urandom_range(3) == 0) begin
      n = $urandom_range(6, 1);
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else if (long_stall) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(4) != 0);
  end

  always @(posedge clk) begin
    sem_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_cnt++;
      end else begin
        want = replies_due.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d got %0d", want.status, out_status);
          fail_cnt++;
        end
        if (out_result_proc !== want.proc_num) begin
          $error("result_proc: expected %0d got %0d", want.proc_num, out_result_proc);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_corner_cases();
    send_op(OP_WAKE, 32'h0, 5'd0);
    send_op(OP_PEEK, 32'hFFFF_FFFF, 5'd0);
    send_op(OP_UNBLOCK, 32'h0, 5'd31);
    send_op(OP_BLOCK, 32'hFFFF_FFFF, 5'd31);
    send_op(OP_BLOCK, 32'hFFFF_FFFF, 5'd31);
    send_op(OP_BLOCK, 32'hFFFF_FFFF, 5'd0);
    send_op(OP_BLOCK, 32'hFFFF_FFFF, 5'd7);
    send_op(OP_PEEK, 32'hFFFF_FFFF, 5'd0);
    send_op(OP_UNBLOCK, 32'h0, 5'd0);
    send_op(OP_UNBLOCK, 32'h0, 5'd7);
    send_op(OP_BLOCK, 32'h0, 5'd3);
    send_op(OP_WAKE, 32'hFFFF_FFFF, 5'd0);
    send_op(OP_WAKE, 32'hFFFF_FFFF, 5'd0);
    send_op(OP_WAKE, 32'h0, 5'd0);
    send_op(OP_PEEK, 32'h0, 5'd0);
  endtask

  // every process on its own key; process 4 then moves to a new key, and its second block is refused as it waits
  task automatic test_pool_exhaustion();
    for (int i = 0; i < NP; i++) send_op(OP_BLOCK, 32'h1000 + i, i[4:0]);
    send_op(OP_UNBLOCK, 32'h0, 5'd4);
    send_op(OP_BLOCK, 32'hDEAD_BEEF, 5'd4);
    send_op(OP_BLOCK, 32'hCAFE_0000, 5'd4);
    for (int i = 0; i < NP; i++) send_op(OP_UNBLOCK, 32'h0, i[4:0]);
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 40; i++)
        send_op(op_t'($urandom_range(3)), key_pool[$urandom_range(3)],
                5'($urandom_range(31)));
    join
    wait_drained();
  endtask

  task automatic test_random_traffic(int n);
    logic [31:0] k;
    op_t op;
    for (int i = 0; i < n; i++) begin
      long_stall = (i % 200) < 40;
      if (i % 150 == 149) wait_drained();
      else if (!long_stall) random_gap();
      if ($urandom_range(9) == 0) k = $urandom;
      else k = key_pool[$urandom_range(7)];
      op = op_t'($urandom_range(3));
      send_op(op, k, 5'($urandom_range(31)));
    end
    long_stall = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_op = '0; in_sem_key = '0; in_proc_id = '0;
    out_ready = 1'b0; fail_cnt = 0; hold_off = 1'b0; long_stall = 1'b0; idle_cycles = 0;
    for (int d = 0; d < NP; d++) begin
      sem_busy[d] = 1'b0; proc_blocked[d] = 1'b0; proc_sem[d] = 0;
    end
    key_pool = '{32'h0, 32'hFFFF_FFFF, 32'hAAAA_5555, 32'h5555_AAAA,
                 $urandom, $urandom, $urandom, $urandom};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_cases();
    test_pool_exhaustion();
    test_backpressure();
    test_random_traffic(700);
    wait_drained();
    if (fail_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
